[rtl/merge_sorter_assert.svh]
// merge_sorter_assert.svh: assertion macros for the merge sorter checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MERGE_SORTER_ASSERT_SVH
`define MERGE_SORTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MSRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge_sorter assertion failed");

// antecedent implies consequent in the next cycle
`define MSRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge_sorter assertion failed");

`endif

[rtl/msrt_pkg.sv]
// msrt_pkg: shared types and data width constant of the merge sorter
// no dependencies
`timescale 1ns / 1ps

package msrt_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SETUP,
    ST_MERGE,
    ST_DRAIN
  } msrt_state_e;

  typedef struct packed {
    logic strobe;
    logic end_of_block;
    logic overflow;
    logic src_sel;
  } res_flags_t;

endpackage

[rtl/merge_sorter.sv]
// merge_sorter: top level, sequencer plus two ping-pong value stores
// depends on msrt_pkg, msrt_ctrl, msrt_ram
//
// usage:
//   an item (value_i, last_item_i) is taken at a rising edge with start_i high
//   and busy_o low; items without the last mark keep busy_o low, so items can
//   follow back to back. items beyond MAX_ITEMS are dropped and flag overflow.
//   the item marked last closes the block: busy_o rises and the stored n
//   values are sorted by bottom-up merge passes that alternate between two
//   rams, one output element per cycle from a two read port ram, plus a setup
//   state per merged run pair (covers the registered read).
//   sort time: ceil(log2 n) passes over all n values plus the setup states.
//   readout: results appear one per cycle on sorted_value_o with strobe_o,
//   the final one with end_of_block_o; overflow_o is set on every result of a
//   block that lost items. the final result shows in the cycle busy_o falls,
//   so the next block can start while it is delivered.
//   results last exactly one cycle; the receiver cannot stall.
//   reset: asynchronous, active low; empties the block, stores need no clear.
`timescale 1ns / 1ps

module merge_sorter
  import msrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_item_i,
  output logic                    strobe_o,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    end_of_block_o,
  output logic                    overflow_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [1:0][DataW-1:0] rdata_a, rdata_b;
  logic [1:0]            we;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DataW-1:0]      wdata;
  res_flags_t            flags;

  msrt_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .last_item_i (last_item_i),
    .busy_o      (busy_o),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .flags_o     (flags)
  );

  for (genvar g = 0; g < 2; g++) begin : g_store
    msrt_ram #(
      .Depth (MAX_ITEMS),
      .AddrW (AW)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (we[g]),
      .waddr_i   (waddr),
      .wdata_i   (wdata),
      .raddr_a_i (raddr_a),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rdata_a[g]),
      .rdata_b_o (rdata_b[g])
    );
  end

  assign strobe_o       = flags.strobe;
  assign end_of_block_o = flags.end_of_block;
  assign overflow_o     = flags.overflow;
  assign sorted_value_o = flags.src_sel ? rdata_a[1] : rdata_a[0];

endmodule

[rtl/msrt_ram.sv]
// msrt_ram: two read port, one write port synchronous ram, registered reads
// depends on msrt_pkg
`timescale 1ns / 1ps

module msrt_ram
  import msrt_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_a_o,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/msrt_ctrl.sv]
// msrt_ctrl: collect, bottom-up merge pass and drain sequencer
// depends on msrt_pkg; drives two msrt_ram instances used as ping-pong stores
`timescale 1ns / 1ps

module msrt_ctrl
  import msrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DataW-1:0]       value_i,
  input  logic                   last_item_i,
  output logic                   busy_o,
  input  logic [1:0][DataW-1:0]  rdata_a_i,
  input  logic [1:0][DataW-1:0]  rdata_b_i,
  output logic [1:0]             we_o,
  output logic [AW-1:0]          waddr_o,
  output logic [DataW-1:0]       wdata_o,
  output logic [AW-1:0]          raddr_a_o,
  output logic [AW-1:0]          raddr_b_o,
  output res_flags_t             flags_o
);

  localparam int unsigned PW = CW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);
  localparam logic [PW-1:0] One = PW'(1);

  msrt_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          sel_q, sel_d;
  logic [PW-1:0] width_q, width_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [PW-1:0] mid_q, mid_d;
  logic [PW-1:0] hi_q, hi_d;
  logic [PW-1:0] a_q, a_d;
  logic [PW-1:0] b_q, b_d;
  logic [PW-1:0] k_q, k_d;
  logic          strobe_q, eob_q, ovf_out_q;

  logic          accept;
  logic          store_ok;
  logic [CW-1:0] cnt_next;
  logic [PW-1:0] nn;
  logic [PW-1:0] sum1, sum2, mid_c, hi_c;
  logic [DataW-1:0] head_a, head_b;
  logic          take_left;
  logic          merge_end, pass_end, sort_end, drain_end;
  logic [PW-1:0] width_dbl;

  assign busy_o    = (state_q != ST_COLLECT);
  assign accept    = start_i && !busy_o;
  assign store_ok  = (cnt_q < MaxCnt);
  assign cnt_next  = cnt_q + CW'(store_ok);
  assign nn        = PW'(cnt_q);
  assign sum1      = lo_q + width_q;
  assign sum2      = sum1 + width_q;
  assign mid_c     = (sum1 > nn) ? nn : sum1;
  assign hi_c      = (sum2 > nn) ? nn : sum2;
  assign head_a    = sel_q ? rdata_a_i[1] : rdata_a_i[0];
  assign head_b    = sel_q ? rdata_b_i[1] : rdata_b_i[0];
  assign take_left = (a_q < mid_q) &&
                     ((b_q >= hi_q) || ($signed(head_a) < $signed(head_b)));
  assign merge_end = ((k_q + One) == hi_q);
  assign pass_end  = merge_end && (hi_q == nn);
  assign width_dbl = width_q << 1;
  assign sort_end  = pass_end && (width_dbl >= nn);
  assign drain_end = (k_q == (nn - One));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (accept && last_item_i) begin
          state_d = (cnt_next == CW'(1)) ? ST_DRAIN : ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_MERGE;
      ST_MERGE: begin
        if (sort_end) begin
          state_d = ST_DRAIN;
        end else if (merge_end) begin
          state_d = ST_SETUP;
        end
      end
      ST_DRAIN: begin
        if (drain_end) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    sel_d     = sel_q;
    width_d   = width_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    we_o      = 2'b00;
    waddr_o   = k_q[AW-1:0];
    wdata_o   = take_left ? head_a : head_b;
    raddr_a_o = a_q[AW-1:0];
    raddr_b_o = b_q[AW-1:0];
    unique case (state_q)
      ST_COLLECT: begin
        waddr_o = cnt_q[AW-1:0];
        wdata_o = value_i;
        if (accept) begin
          we_o[0] = store_ok;
          cnt_d   = cnt_next;
          ovf_d   = ovf_q | !store_ok;
          if (last_item_i) begin
            sel_d   = 1'b0;
            width_d = One;
            lo_d    = '0;
            k_d     = '0;
          end
        end
      end
      ST_SETUP: begin
        mid_d     = mid_c;
        hi_d      = hi_c;
        a_d       = lo_q;
        b_d       = mid_c;
        k_d       = lo_q;
        raddr_a_o = lo_q[AW-1:0];
        raddr_b_o = mid_c[AW-1:0];
      end
      ST_MERGE: begin
        we_o[0]   = sel_q;
        we_o[1]   = !sel_q;
        a_d       = a_q + PW'(take_left);
        b_d       = b_q + PW'(!take_left);
        k_d       = k_q + One;
        raddr_a_o = a_d[AW-1:0];
        raddr_b_o = b_d[AW-1:0];
        if (pass_end) begin
          sel_d   = !sel_q;
          width_d = width_dbl;
          lo_d    = '0;
          if (sort_end) begin
            k_d = '0;
          end
        end else if (merge_end) begin
          lo_d = hi_q;
        end
      end
      ST_DRAIN: begin
        raddr_a_o = k_q[AW-1:0];
        k_d       = k_q + One;
        if (drain_end) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sel_q     <= 1'b0;
      strobe_q  <= 1'b0;
      eob_q     <= 1'b0;
      ovf_out_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      sel_q     <= sel_d;
      strobe_q  <= (state_q == ST_DRAIN);
      eob_q     <= (state_q == ST_DRAIN) && drain_end;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    lo_q    <= lo_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    a_q     <= a_d;
    b_q     <= b_d;
    k_q     <= k_d;
  end

  assign flags_o.strobe       = strobe_q;
  assign flags_o.end_of_block = eob_q;
  assign flags_o.overflow     = ovf_out_q;
  assign flags_o.src_sel      = sel_q;

endmodule

[rtl/msrt_checker.sv]
// msrt_checker: port level assertions for merge_sorter, with its bind
// depends on merge_sorter_assert.svh
`timescale 1ns / 1ps
`include "merge_sorter_assert.svh"

module msrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_item_i,
  input logic strobe_o,
  input logic end_of_block_o
);

  `MSRT_ASSERT_NXT(a_last_sets_busy, start_i && !busy_o && last_item_i, busy_o)
  `MSRT_ASSERT_NXT(a_plain_item_idle, start_i && !busy_o && !last_item_i, !busy_o && !strobe_o)
  `MSRT_ASSERT_IMP(a_mid_result_busy, strobe_o && !end_of_block_o, busy_o)
  `MSRT_ASSERT_NXT(a_eob_ends_block, strobe_o && end_of_block_o, !strobe_o)

endmodule

bind merge_sorter msrt_checker u_msrt_checker (.*);
